// File: hw/rtl/acl_binner_pkg.sv
// Shared types, codes and default sizes for the cell-list binner.
// No dependencies; imported by the binner top and the box bound unit.
package acl_binner_pkg;

	localparam int DEF_GRID_X   = 16;
	localparam int DEF_GRID_Y   = 16;
	localparam int DEF_GRID_Z   = 16;
	localparam int DEF_CELL_CAP = 16;
	localparam int DEF_MAX_SPAN = 4;

	localparam int CW_COORD = 24;   // Q15.8 coordinate
	localparam int CW_RAD   = 12;   // Q4.8 radius
	localparam int CW_INV   = 24;   // Q8.16 reciprocal spacing
	localparam int FRAC     = 24;   // fraction bits of the product
	localparam int QW       = 27;   // width of a rounded axis index

	localparam logic [2:0] CFG_CORNER_X = 3'd0;
	localparam logic [2:0] CFG_CORNER_Y = 3'd1;
	localparam logic [2:0] CFG_CORNER_Z = 3'd2;
	localparam logic [2:0] CFG_INV_X    = 3'd3;
	localparam logic [2:0] CFG_INV_Y    = 3'd4;
	localparam logic [2:0] CFG_INV_Z    = 3'd5;
	localparam logic [2:0] CFG_PROBE    = 3'd6;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_OFF  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_DECIDE,
		S_WALK,
		S_DRAIN
	} state_t;

endpackage

// File: hw/rtl/atom_cell_list_binner.sv
// 3D cell-list binner top: config registers, control sequencer, cell walk.
// Locate, off-grid and empty-box items give a single result; a new start is
// taken only once the sequencer is back in idle (busy low).
// An insert walks one cell per cycle, set by the count memory read-modify-write
// port, and gives one result per cell walked.
// Reset: asynchronous; a clearing pass zeroes GRID_X*GRID_Y*GRID_Z counts, one
// a cycle, with busy high. Results are one-cycle strobes; the receiver cannot stall.
module atom_cell_list_binner
	#(
	parameter int GRID_X   = acl_binner_pkg::DEF_GRID_X,
	parameter int GRID_Y   = acl_binner_pkg::DEF_GRID_Y,
	parameter int GRID_Z   = acl_binner_pkg::DEF_GRID_Z,
	parameter int CELL_CAP = acl_binner_pkg::DEF_CELL_CAP,
	parameter int MAX_SPAN = acl_binner_pkg::DEF_MAX_SPAN
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// command side
	input  logic                                      start,
	output logic                                      busy,
	input  logic                                      mode,
	input  logic [15:0]                               atom_id,
	input  logic signed [acl_binner_pkg::CW_COORD-1:0] pos_x,
	input  logic signed [acl_binner_pkg::CW_COORD-1:0] pos_y,
	input  logic signed [acl_binner_pkg::CW_COORD-1:0] pos_z,
	input  logic [acl_binner_pkg::CW_RAD-1:0]          radius,
	// result side
	output logic                                      result_valid,
	output logic [11:0]                               cell_index,
	output logic [3:0]                                slot,
	output logic [1:0]                                status,
	output logic                                      clipped,
	output logic                                      last,
	// configuration write channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [2:0]                                cfg_index,
	input  logic [23:0]                               cfg_data
);
	import acl_binner_pkg::*;

	localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int CA     = $clog2(NCELLS);
	localparam int NW     = $clog2(CELL_CAP + 1);
	localparam int SDEPTH = NCELLS * CELL_CAP;
	localparam int SA     = $clog2(SDEPTH);
	localparam int GMX    = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
	                                          : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
	localparam int IW     = $clog2(GMX);

	// configuration registers
	logic signed [CW_COORD-1:0] corner_q [3];
	logic        [CW_INV-1:0]   inv_q [3];
	logic        [CW_RAD-1:0]   probe_q;

	// latched item
	logic                       mode_q;
	logic [15:0]                id_q;
	logic signed [CW_COORD-1:0] pos_q [3];
	logic [CW_RAD-1:0]          rad_q;

	state_t state_q, state_d;
	logic [CA-1:0] clr_q;

	// walk bounds and cursor
	logic [IW-1:0] wlo_q [3];
	logic [IW-1:0] whi_q [3];
	logic [IW-1:0] cur_q [3];
	logic          clip_q;

	// read stage of the walk
	logic          vld_s1;
	logic [CA-1:0] cell_s1;
	logic          last_s1;

	// result register
	logic          rv_q;
	logic [11:0]   ci_q;
	logic [3:0]    sl_q;
	status_t       st_q;
	logic          cl_q;
	logic          ls_q;

	logic                 go;
	logic                 calc_done;
	logic signed [QW-1:0] lo [3];
	logic signed [QW-1:0] hi [3];

	logic                 accept;
	logic                 off_grid;
	logic                 empty_box;
	logic                 wide [3];
	logic signed [QW-1:0] gmax [3];
	logic [IW-1:0]        chi [3];
	logic [CA-1:0]        loc_cell;
	logic [CA-1:0]        cur_cell;
	logic                 at_end;

	logic          mem_we;
	logic [CA-1:0] mem_waddr;
	logic [NW-1:0] mem_wdata;
	logic [NW-1:0] mem_rdata;
	logic          slot_we;
	logic [SA-1:0] slot_waddr;
	logic          has_room;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign go        = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '{default: '0};
			inv_q    <= '{default: CW_INV'(65536)};
			probe_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CORNER_X: corner_q[0] <= cfg_data;
				CFG_CORNER_Y: corner_q[1] <= cfg_data;
				CFG_CORNER_Z: corner_q[2] <= cfg_data;
				CFG_INV_X:    inv_q[0]    <= cfg_data;
				CFG_INV_Y:    inv_q[1]    <= cfg_data;
				CFG_INV_Z:    inv_q[2]    <= cfg_data;
				CFG_PROBE:    probe_q     <= cfg_data[CW_RAD-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			id_q     <= atom_id;
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			rad_q    <= radius;
		end
	end

	acl_box_calc #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z)
	) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.locate (mode_q),
		.pos    (pos_q),
		.radius (rad_q),
		.corner (corner_q),
		.inv    (inv_q),
		.probe  (probe_q),
		.lo     (lo),
		.hi     (hi),
		.done   (calc_done)
	);

	// box decisions on the finished bounds
	assign gmax[0] = QW'(GRID_X - 1);
	assign gmax[1] = QW'(GRID_Y - 1);
	assign gmax[2] = QW'(GRID_Z - 1);

	always_comb begin
		off_grid  = 1'b0;
		empty_box = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (hi[a] < 0 || hi[a] > gmax[a]) off_grid = 1'b1;
			if (lo[a] > hi[a]) empty_box = 1'b1;
			wide[a] = (hi[a] - lo[a]) >= QW'(MAX_SPAN);
			chi[a]  = wide[a] ? IW'(lo[a][IW-1:0] + IW'(MAX_SPAN - 1)) : hi[a][IW-1:0];
		end
		loc_cell = (CA'(hi[0][IW-1:0]) * CA'(GRID_Y) + CA'(hi[1][IW-1:0])) * CA'(GRID_Z)
		         + CA'(hi[2][IW-1:0]);
		cur_cell = (CA'(cur_q[0]) * CA'(GRID_Y) + CA'(cur_q[1])) * CA'(GRID_Z)
		         + CA'(cur_q[2]);
		at_end   = (cur_q[0] == whi_q[0]) && (cur_q[1] == whi_q[1])
		         && (cur_q[2] == whi_q[2]);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == CA'(NCELLS - 1)) state_d = S_IDLE;
			S_IDLE:   if (start) state_d = S_CALC;
			S_CALC:   if (calc_done) state_d = S_DECIDE;
			S_DECIDE: state_d = (mode_q || empty_box) ? S_IDLE : S_WALK;
			S_WALK:   if (at_end) state_d = S_DRAIN;
			S_DRAIN:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + CA'(1);
			vld_s1 <= (state_q == S_WALK);
			rv_q   <= (state_q == S_DECIDE && (mode_q || empty_box)) || vld_s1;
		end
	end

	// walk cursor: z inner, then y, then x
	always_ff @(posedge clk) begin
		cell_s1 <= cur_cell;
		last_s1 <= at_end;
		if (state_q == S_DECIDE) begin
			clip_q <= wide[0] || wide[1] || wide[2];
			for (int a = 0; a < 3; a++) begin
				wlo_q[a] <= lo[a][IW-1:0];
				whi_q[a] <= chi[a];
				cur_q[a] <= lo[a][IW-1:0];
			end
		end else if (state_q == S_WALK) begin
			if (cur_q[2] != whi_q[2]) begin
				cur_q[2] <= cur_q[2] + IW'(1);
			end else begin
				cur_q[2] <= wlo_q[2];
				if (cur_q[1] != whi_q[1]) begin
					cur_q[1] <= cur_q[1] + IW'(1);
				end else begin
					cur_q[1] <= wlo_q[1];
					cur_q[0] <= cur_q[0] + IW'(1);
				end
			end
		end
	end

	// count read-modify-write; cells of one walk are distinct, so no overlap
	assign has_room   = mem_rdata < NW'(CELL_CAP);
	assign mem_we     = (state_q == S_CLEAR) || (vld_s1 && has_room);
	assign mem_waddr  = (state_q == S_CLEAR) ? clr_q : cell_s1;
	assign mem_wdata  = (state_q == S_CLEAR) ? '0 : NW'(mem_rdata + NW'(1));
	assign slot_we    = vld_s1 && has_room;
	assign slot_waddr = SA'(cell_s1) * SA'(CELL_CAP) + SA'(mem_rdata);

	acl_count_ram #(
		.DEPTH(NCELLS),
		.DW   (NW)
	) u_count (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cur_cell),
		.rdata (mem_rdata)
	);

	acl_slot_ram #(
		.DEPTH(SDEPTH),
		.DW   (16)
	) u_slots (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (id_q)
	);

	// result register
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ci_q <= 12'(cell_s1);
			sl_q <= has_room ? 4'(mem_rdata) : 4'd0;
			st_q <= has_room ? ST_OK : ST_FULL;
			cl_q <= clip_q;
			ls_q <= last_s1;
		end else begin
			sl_q <= 4'd0;
			cl_q <= 1'b0;
			ls_q <= 1'b1;
			if (mode_q && !off_grid) begin
				ci_q <= 12'(loc_cell);
				st_q <= ST_OK;
			end else begin
				ci_q <= 12'd0;
				st_q <= ST_OFF;
			end
		end
	end

	assign result_valid = rv_q;
	assign cell_index   = ci_q;
	assign slot         = sl_q;
	assign status       = st_q;
	assign clipped      = cl_q;
	assign last         = ls_q;
endmodule

// File: hw/rtl/acl_count_ram.sv
// Per-cell occupancy count memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module acl_count_ram #(
	parameter int DEPTH = 4096,
	parameter int DW    = 5
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/acl_slot_ram.sv
// Atom id slot store, CELL_CAP slots per cell, write only.
// Depends on nothing but its parameters.
module acl_slot_ram #(
	parameter int DEPTH = 65536,
	parameter int DW    = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// File: hw/rtl/acl_box_calc.sv
// Box bound unit: one shared multiplier, six steps (ceil/floor per axis, the
// upper one truncating in locate mode), two-stage pipeline. Depends on acl_binner_pkg.
module acl_box_calc #(
	parameter int GRID_X = acl_binner_pkg::DEF_GRID_X,
	parameter int GRID_Y = acl_binner_pkg::DEF_GRID_Y,
	parameter int GRID_Z = acl_binner_pkg::DEF_GRID_Z
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      go,
	input  logic                                      locate,
	input  logic signed [acl_binner_pkg::CW_COORD-1:0] pos [3],
	input  logic        [acl_binner_pkg::CW_RAD-1:0]   radius,
	input  logic signed [acl_binner_pkg::CW_COORD-1:0] corner [3],
	input  logic        [acl_binner_pkg::CW_INV-1:0]   inv [3],
	input  logic        [acl_binner_pkg::CW_RAD-1:0]   probe,
	output logic signed [acl_binner_pkg::QW-1:0]       lo [3],
	output logic signed [acl_binner_pkg::QW-1:0]       hi [3],
	output logic                                      done
);
	import acl_binner_pkg::*;

	localparam int DW = CW_COORD + 1;
	localparam int OW = CW_COORD + 2;
	localparam int PW = OW + CW_INV + 1;

	logic                 run_q;
	logic [2:0]           step_q;
	logic                 vld_s1;
	logic [2:0]           step_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [QW-1:0] lo_q [3];
	logic signed [QW-1:0] hi_q [3];

	logic [1:0]            ax;
	logic signed [DW-1:0]  d;
	logic        [CW_RAD:0] rtot;
	logic signed [OW-1:0]  opnd;
	logic signed [PW-1:0]  prod;
	logic [1:0]            ax1;
	logic signed [PW-1:0]  bias;
	logic signed [PW-1:0]  sum;
	logic signed [QW-1:0]  r;
	logic signed [QW-1:0]  gmax;

	always_comb begin
		ax   = step_q[2:1];
		d    = DW'(pos[ax]) - DW'(corner[ax]);
		rtot = (CW_RAD+1)'(radius) + (CW_RAD+1)'(probe);
		if (locate) begin
			opnd = OW'(d);
		end else if (step_q[0]) begin
			opnd = OW'(d) - $signed(OW'(rtot));
		end else begin
			opnd = OW'(d) + $signed(OW'(rtot));
		end
		prod = opnd * $signed({1'b0, inv[ax]});
	end

	always_comb begin
		ax1 = step_s1[2:1];
		if (step_s1[0]) begin
			bias = '0;                                     // floor
		end else if (!locate || prod_s1 < 0) begin
			bias = PW'((64'd1 << FRAC) - 64'd1);           // ceil, or trunc of negative
		end else begin
			bias = '0;
		end
		sum = prod_s1 + bias;
		r   = QW'(sum >>> FRAC);
		case (ax1)
			2'd0:    gmax = QW'(GRID_X - 1);
			2'd1:    gmax = QW'(GRID_Y - 1);
			default: gmax = QW'(GRID_Z - 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= run_q;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		prod_s1 <= prod;
		if (vld_s1) begin
			if (step_s1[0]) begin
				lo_q[ax1] <= (r < 0) ? '0 : r;
			end else if (locate) begin
				hi_q[ax1] <= r;
			end else begin
				hi_q[ax1] <= (r > gmax) ? gmax : r;
			end
		end
	end

	assign lo   = lo_q;
	assign hi   = hi_q;
	assign done = vld_s1 && (step_s1 == 3'd5);
endmodule
